FILE: design/skt_pkg.sv
package skt_pkg;

   localparam int DEPTH_DEF    = 64;
   localparam int KEY_BITS_DEF = 16;

   localparam int HANDLE_W  = 6;
   localparam int REQ_KEY_W = 16;
   localparam int POS_W     = 7;
   localparam int CNT_W     = 7;

   typedef enum logic [2:0] {
      OP_INSERT,
      OP_APPEND,
      OP_REMOVE,
      OP_MOVE,
      OP_LOWER,
      OP_UPPER,
      OP_SORT,
      OP_CLEAR
   } opcode_type;

   typedef enum logic [1:0] {
      STS_OK,
      STS_FULL,
      STS_ABSENT,
      STS_PRESENT
   } status_type;

   typedef struct packed {
      opcode_type                  opcode;
      logic [HANDLE_W-1:0]         handle;
      logic signed [REQ_KEY_W-1:0] key;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic [POS_W-1:0]   position;
      logic               was_sorted;
      logic [CNT_W-1:0]   entry_count;
   } rsp_type;

   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_REMOVE,
      CELL_STEP_UP,
      CELL_STEP_DN,
      CELL_WRITE,
      CELL_SORT
   } cell_kind_type;

   typedef struct packed {
      cell_kind_type kind;
      logic          phase;
   } cell_ctl_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_LOOK,
      S_EXEC,
      S_SEARCH,
      S_MOVE_UP,
      S_MOVE_DN,
      S_SORT,
      S_DONE
   } state_type;

endpackage

FILE: design/sorted_key_table_unit.sv
// Sorted key table: up to DEPTH entries of (signed key, 6-bit handle) held in
// a row of cells, one slot per cell, each cell shifting with its neighbors.
// Requests enter on req_* (opcode, handle, key); one response per request
// leaves on rsp_* (status, position, was_sorted, entry_count).
// A request is taken only while the table is idle; req_stall is high while a
// request is in work or its response waits to be registered.
// Append, remove, clear and errors go straight to the response; lower/upper
// bound and insert run a halving search, move shifts the entry one slot per
// cycle upward (or else downward), and sort runs odd/even phases over the
// cell row until neither phase swaps a pair.
// A finished response sits in an output register; a new request is accepted
// while it waits, and the following response holds until rsp_stall drops.
// Reset empties the table (entry count zero) and drops rsp_valid.
module sorted_key_table_unit import skt_pkg::*; #(
   parameter int DEPTH    = DEPTH_DEF,
   parameter int KEY_BITS = KEY_BITS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_payload
);

   localparam int CW = $clog2(DEPTH + 1);

   cell_ctl_type               ctl;
   logic [CW-1:0]              cell_pos;
   logic [CW-1:0]              fill;
   logic signed [KEY_BITS-1:0] new_key;
   logic [HANDLE_W-1:0]        new_handle;
   logic [DEPTH-1:0]           above_vec, below_vec, match_vec, swap_vec;
   logic signed [KEY_BITS-1:0] cell_keys [DEPTH];
   logic [HANDLE_W-1:0]        cell_handles [DEPTH];

   skt_ctrl #(
      .DEPTH    (DEPTH),
      .KEY_BITS (KEY_BITS)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .ctl         (ctl),
      .cell_pos    (cell_pos),
      .fill        (fill),
      .new_key     (new_key),
      .new_handle  (new_handle),
      .above_vec   (above_vec),
      .below_vec   (below_vec),
      .match_vec   (match_vec),
      .swap_vec    (swap_vec)
   );

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic signed [KEY_BITS-1:0] lk, rk;
      logic [HANDLE_W-1:0]        lh, rh;
      logic                       ls;

      if (i == 0) begin : g_first
         assign lk = '0;
         assign lh = '0;
         assign ls = 1'b0;
      end else begin : g_left
         assign lk = cell_keys[i-1];
         assign lh = cell_handles[i-1];
         assign ls = swap_vec[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign rk = '0;
         assign rh = '0;
      end else begin : g_right
         assign rk = cell_keys[i+1];
         assign rh = cell_handles[i+1];
      end

      skt_cell #(
         .DEPTH    (DEPTH),
         .KEY_BITS (KEY_BITS),
         .INDEX    (i)
      ) u_cell (
         .clock        (clock),
         .ctl          (ctl),
         .cell_pos     (cell_pos),
         .fill         (fill),
         .new_key      (new_key),
         .new_handle   (new_handle),
         .left_key     (lk),
         .left_handle  (lh),
         .left_swap    (ls),
         .right_key    (rk),
         .right_handle (rh),
         .cell_key     (cell_keys[i]),
         .cell_handle  (cell_handles[i]),
         .swap         (swap_vec[i]),
         .above        (above_vec[i]),
         .below        (below_vec[i]),
         .match        (match_vec[i])
      );
   end

endmodule

FILE: design/skt_cell.sv
module skt_cell import skt_pkg::*; #(
   parameter int DEPTH    = DEPTH_DEF,
   parameter int KEY_BITS = KEY_BITS_DEF,
   parameter int INDEX    = 0,
   localparam int CW      = $clog2(DEPTH + 1)
) (
   input  logic                       clock,
   input  cell_ctl_type               ctl,
   input  logic [CW-1:0]              cell_pos,
   input  logic [CW-1:0]              fill,
   input  logic signed [KEY_BITS-1:0] new_key,
   input  logic [HANDLE_W-1:0]        new_handle,
   input  logic signed [KEY_BITS-1:0] left_key,
   input  logic [HANDLE_W-1:0]        left_handle,
   input  logic                       left_swap,
   input  logic signed [KEY_BITS-1:0] right_key,
   input  logic [HANDLE_W-1:0]        right_handle,
   output logic signed [KEY_BITS-1:0] cell_key,
   output logic [HANDLE_W-1:0]        cell_handle,
   output logic                       swap,
   output logic                       above,
   output logic                       below,
   output logic                       match
);

   localparam logic [CW-1:0] IDX      = CW'(INDEX);
   localparam logic [CW-1:0] IDX_NEXT = CW'(INDEX + 1);
   localparam logic          PARITY   = 1'(INDEX % 2);

   logic signed [KEY_BITS-1:0] key_ff, key_in;
   logic [HANDLE_W-1:0]        handle_ff, handle_in;
   logic                       above_ff, below_ff, match_ff;
   logic                       valid, right_valid;

   assign valid       = IDX < fill;
   assign right_valid = IDX_NEXT < fill;

   // left member of an active odd/even pair that is out of order
   assign swap = (ctl.kind == CELL_SORT) && (ctl.phase == PARITY) && right_valid &&
                 (key_ff > right_key);

   always_comb begin
      key_in    = key_ff;
      handle_in = handle_ff;
      case (ctl.kind)
         CELL_INSERT: begin
            if (IDX > cell_pos) begin
               key_in    = left_key;
               handle_in = left_handle;
            end else if (IDX == cell_pos) begin
               key_in    = new_key;
               handle_in = new_handle;
            end
         end
         CELL_REMOVE: begin
            if (IDX >= cell_pos) begin
               key_in    = right_key;
               handle_in = right_handle;
            end
         end
         CELL_STEP_UP: begin
            if (IDX == cell_pos) begin
               key_in    = right_key;
               handle_in = right_handle;
            end
         end
         CELL_STEP_DN: begin
            if (IDX == cell_pos) begin
               key_in    = left_key;
               handle_in = left_handle;
            end
         end
         CELL_WRITE: begin
            if (IDX == cell_pos) begin
               key_in    = new_key;
               handle_in = new_handle;
            end
         end
         CELL_SORT: begin
            if (swap) begin
               key_in    = right_key;
               handle_in = right_handle;
            end else if (left_swap) begin
               key_in    = left_key;
               handle_in = left_handle;
            end
         end
         default: begin
            key_in    = key_ff;
            handle_in = handle_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      key_ff    <= key_in;
      handle_ff <= handle_in;
      above_ff  <= new_key > key_ff;
      below_ff  <= new_key < key_ff;
      match_ff  <= valid && (handle_ff == new_handle);
   end

   assign cell_key    = key_ff;
   assign cell_handle = handle_ff;
   assign above       = above_ff;
   assign below       = below_ff;
   assign match       = match_ff;

endmodule

FILE: design/skt_ctrl.sv
module skt_ctrl import skt_pkg::*; #(
   parameter int DEPTH    = DEPTH_DEF,
   parameter int KEY_BITS = KEY_BITS_DEF,
   localparam int CW      = $clog2(DEPTH + 1)
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  req_type                    req_payload,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output rsp_type                    rsp_payload,
   output cell_ctl_type               ctl,
   output logic [CW-1:0]              cell_pos,
   output logic [CW-1:0]              fill,
   output logic signed [KEY_BITS-1:0] new_key,
   output logic [HANDLE_W-1:0]        new_handle,
   input  logic [DEPTH-1:0]           above_vec,
   input  logic [DEPTH-1:0]           below_vec,
   input  logic [DEPTH-1:0]           match_vec,
   input  logic [DEPTH-1:0]           swap_vec
);

   localparam int AW = $clog2(DEPTH);
   localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

   state_type        state_ff, state_in;
   req_type          req_ff, req_in;
   logic [CW-1:0]    fill_ff, fill_in;
   logic [CW-1:0]    lo_ff, lo_in;
   logic [CW-1:0]    hi_ff, hi_in;
   logic [CW-1:0]    pos_ff, pos_in;
   logic             moved_ff, moved_in;
   logic             phase_ff, phase_in;
   logic             quiet_ff, quiet_in;
   logic             any_ff, any_in;
   status_type       res_status_ff, res_status_in;
   logic [CW-1:0]    res_pos_ff, res_pos_in;
   logic             res_sorted_ff, res_sorted_in;
   rsp_type          rsp_ff, rsp_in;
   logic             rsp_valid_ff, rsp_valid_in;

   logic             present;
   logic [CW-1:0]    slot;
   logic [CW-1:0]    mid;
   logic             search_up;
   logic [CW-1:0]    pos_next, pos_prev;
   logic             up_ok, dn_ok;
   logic             swap_any;
   logic             out_free;
   logic             full;
   logic             sort_done;

   if (KEY_BITS <= REQ_KEY_W) begin : g_key_narrow
      assign new_key = req_ff.key[KEY_BITS-1:0];
   end else begin : g_key_wide
      assign new_key = {{(KEY_BITS - REQ_KEY_W){req_ff.key[REQ_KEY_W-1]}}, req_ff.key};
   end

   assign new_handle = req_ff.handle;
   assign fill       = fill_ff;

   assign present = |match_vec;

   always_comb begin
      slot = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (match_vec[i]) begin
            slot = slot | CW'(i);
         end
      end
   end

   assign mid       = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign search_up = (req_ff.opcode == OP_UPPER) ? !below_vec[mid[AW-1:0]]
                                                  : above_vec[mid[AW-1:0]];
   assign pos_next  = pos_ff + 1'b1;
   assign pos_prev  = pos_ff - 1'b1;
   assign up_ok     = (pos_next < fill_ff) && above_vec[pos_next[AW-1:0]];
   assign dn_ok     = (pos_ff != '0) && below_vec[pos_prev[AW-1:0]];
   assign swap_any  = |swap_vec;
   assign sort_done = !swap_any && quiet_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign full      = fill_ff >= DEPTH_C;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:   if (req_valid) state_in = S_LOOK;
         S_LOOK:   state_in = S_EXEC;
         S_EXEC: begin
            case (req_ff.opcode)
               OP_INSERT: state_in = (present || full) ? S_DONE : S_SEARCH;
               OP_MOVE:   state_in = present ? S_MOVE_UP : S_DONE;
               OP_LOWER:  state_in = S_SEARCH;
               OP_UPPER:  state_in = S_SEARCH;
               OP_SORT:   state_in = S_SORT;
               default:   state_in = S_DONE;
            endcase
         end
         S_SEARCH:  if (lo_ff == hi_ff) state_in = S_DONE;
         S_MOVE_UP: if (!up_ok) state_in = moved_ff ? S_DONE : S_MOVE_DN;
         S_MOVE_DN: if (!dn_ok) state_in = S_DONE;
         S_SORT:    if (sort_done) state_in = S_DONE;
         S_DONE:    if (out_free) state_in = S_IDLE;
         default:   state_in = S_IDLE;
      endcase
   end

   // cell command
   always_comb begin
      ctl.kind  = CELL_HOLD;
      ctl.phase = phase_ff;
      cell_pos  = pos_ff;
      case (state_ff)
         S_EXEC: begin
            if (req_ff.opcode == OP_APPEND && !present && !full) begin
               ctl.kind = CELL_INSERT;
               cell_pos = fill_ff;
            end else if (req_ff.opcode == OP_REMOVE && present) begin
               ctl.kind = CELL_REMOVE;
               cell_pos = slot;
            end
         end
         S_SEARCH: begin
            if (lo_ff == hi_ff && req_ff.opcode == OP_INSERT) begin
               ctl.kind = CELL_INSERT;
               cell_pos = lo_ff;
            end
         end
         S_MOVE_UP: begin
            if (up_ok) begin
               ctl.kind = CELL_STEP_UP;
            end else if (moved_ff) begin
               ctl.kind = CELL_WRITE;
            end
         end
         S_MOVE_DN: ctl.kind = dn_ok ? CELL_STEP_DN : CELL_WRITE;
         S_SORT:    ctl.kind = CELL_SORT;
         default:   ctl.kind = CELL_HOLD;
      endcase
   end

   // datapath registers
   always_comb begin
      req_in        = req_ff;
      fill_in       = fill_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      pos_in        = pos_ff;
      moved_in      = moved_ff;
      phase_in      = phase_ff;
      quiet_in      = quiet_ff;
      any_in        = any_ff;
      res_status_in = res_status_ff;
      res_pos_in    = res_pos_ff;
      res_sorted_in = res_sorted_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in        = req_payload;
               res_status_in = STS_OK;
               res_pos_in    = '0;
               res_sorted_in = 1'b0;
            end
         end
         S_EXEC: begin
            case (req_ff.opcode)
               OP_INSERT, OP_APPEND: begin
                  if (present) begin
                     res_status_in = STS_PRESENT;
                  end else if (full) begin
                     res_status_in = STS_FULL;
                  end else if (req_ff.opcode == OP_APPEND) begin
                     res_pos_in = fill_ff;
                     fill_in    = fill_ff + 1'b1;
                  end else begin
                     lo_in = '0;
                     hi_in = fill_ff;
                  end
               end
               OP_REMOVE: begin
                  if (!present) begin
                     res_status_in = STS_ABSENT;
                  end else begin
                     res_pos_in = slot;
                     fill_in    = fill_ff - 1'b1;
                  end
               end
               OP_MOVE: begin
                  if (!present) begin
                     res_status_in = STS_ABSENT;
                  end else begin
                     pos_in   = slot;
                     moved_in = 1'b0;
                  end
               end
               OP_LOWER, OP_UPPER: begin
                  lo_in = '0;
                  hi_in = fill_ff;
               end
               OP_SORT: begin
                  phase_in = 1'b0;
                  quiet_in = 1'b0;
                  any_in   = 1'b0;
               end
               OP_CLEAR: fill_in = '0;
               default: fill_in = fill_ff;
            endcase
         end
         S_SEARCH: begin
            if (lo_ff == hi_ff) begin
               res_pos_in = lo_ff;
               if (req_ff.opcode == OP_INSERT) begin
                  fill_in = fill_ff + 1'b1;
               end
            end else if (search_up) begin
               lo_in = mid + 1'b1;
            end else begin
               hi_in = mid;
            end
         end
         S_MOVE_UP: begin
            if (up_ok) begin
               pos_in   = pos_next;
               moved_in = 1'b1;
            end else begin
               res_pos_in = pos_ff;
            end
         end
         S_MOVE_DN: begin
            if (dn_ok) begin
               pos_in = pos_prev;
            end else begin
               res_pos_in = pos_ff;
            end
         end
         S_SORT: begin
            if (sort_done) begin
               res_sorted_in = !any_ff;
            end else begin
               quiet_in = !swap_any;
               any_in   = any_ff || swap_any;
               phase_in = !phase_ff;
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_in.status      = res_status_ff;
               rsp_in.position    = POS_W'(res_pos_ff);
               rsp_in.was_sorted  = res_sorted_ff;
               rsp_in.entry_count = CNT_W'(fill_ff);
               rsp_valid_in       = 1'b1;
            end
         end
         default: rsp_in = rsp_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff        <= req_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      pos_ff        <= pos_in;
      moved_ff      <= moved_in;
      phase_ff      <= phase_in;
      quiet_ff      <= quiet_in;
      any_ff        <= any_in;
      res_status_ff <= res_status_in;
      res_pos_ff    <= res_pos_in;
      res_sorted_ff <= res_sorted_in;
      rsp_ff        <= rsp_in;
   end

   assign req_stall   = state_ff != S_IDLE;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

FILE: tb/sv/tb_top.sv
module tb_top;
   import skt_pkg::*;

   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int RANDOM_ITEMS = 1750;
   localparam int CALM_AFTER = 1550;
   localparam int DRAIN_CYCLES = 80;

   typedef struct {
      req_type req;
      bit      typed;
      rsp_type want;
   } script_line_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_payload;

   logic signed [REQ_KEY_W-1:0] slot_key [DEPTH_DEF];
   logic [HANDLE_W-1:0]         slot_owner [DEPTH_DEF];
   int unsigned                 where_is [1 << HANDLE_W];
   int unsigned                 fill;

   rsp_type         want_q [$];
   script_line_type plan [$];
   int              fails = 0;
   int              cycles = 0;
   int              random_sent = 0;
   int unsigned     stall_odds = 0;
   int unsigned     stall_left = 0;

   sorted_key_table_unit i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   function automatic void put_slot(int unsigned s, logic signed [REQ_KEY_W-1:0] k,
         logic [HANDLE_W-1:0] h);
      slot_key[s] = k;
      slot_owner[s] = h;
      where_is[h] = s;
   endfunction

   function automatic int unsigned halving_bound(logic signed [REQ_KEY_W-1:0] k,
         bit upper);
      int unsigned lo;
      int unsigned hi;
      int unsigned p;
      lo = 0;
      hi = fill;
      p = fill / 2;
      while (lo != hi) begin
         if (upper ? (k >= slot_key[p]) : (k > slot_key[p])) lo = p + 1;
         else hi = p;
         p = lo + (hi - lo) / 2;
      end
      return p;
   endfunction

   function automatic rsp_type table_apply(req_type r);
      rsp_type                     o;
      logic signed [REQ_KEY_W-1:0] k;
      logic signed [REQ_KEY_W-1:0] tk;
      logic [HANDLE_W-1:0]         h;
      logic [HANDLE_W-1:0]         th;
      bit                          present;
      bit                          swapped;
      bit                          any;
      int unsigned                 p;
      int unsigned                 i;
      o = '0;
      k = r.key;
      h = r.handle;
      present = where_is[h] < DEPTH_DEF;
      p = 0;
      case (r.opcode)
         OP_INSERT, OP_APPEND: begin
            if (present) o.status = STS_PRESENT;
            else if (fill >= DEPTH_DEF) o.status = STS_FULL;
            else begin
               p = (r.opcode == OP_INSERT) ? halving_bound(k, 1'b0) : fill;
               for (i = fill; i > p; i--) put_slot(i, slot_key[i-1], slot_owner[i-1]);
               put_slot(p, k, h);
               fill++;
            end
         end
         OP_REMOVE: begin
            if (!present) o.status = STS_ABSENT;
            else begin
               p = where_is[h];
               where_is[h] = DEPTH_DEF;
               for (i = p; i + 1 < fill; i++) put_slot(i, slot_key[i+1], slot_owner[i+1]);
               fill--;
            end
         end
         OP_MOVE: begin
            if (!present) o.status = STS_ABSENT;
            else begin
               p = where_is[h];
               while (p + 1 < fill && k > slot_key[p+1]) begin
                  put_slot(p, slot_key[p+1], slot_owner[p+1]);
                  p++;
               end
               while (p > 0 && k < slot_key[p-1]) begin
                  put_slot(p, slot_key[p-1], slot_owner[p-1]);
                  p--;
               end
               put_slot(p, k, h);
            end
         end
         OP_LOWER: p = halving_bound(k, 1'b0);
         OP_UPPER: p = halving_bound(k, 1'b1);
         OP_SORT: begin
            swapped = 1'b1;
            any = 1'b0;
            while (swapped) begin
               swapped = 1'b0;
               for (i = 0; i + 1 < fill; i++) begin
                  if (slot_key[i] > slot_key[i+1]) begin
                     tk = slot_key[i];
                     th = slot_owner[i];
                     put_slot(i, slot_key[i+1], slot_owner[i+1]);
                     put_slot(i + 1, tk, th);
                     swapped = 1'b1;
                     any = 1'b1;
                  end
               end
            end
            o.was_sorted = !any;
         end
         default: begin
            for (i = 0; i < (1 << HANDLE_W); i++) where_is[i] = DEPTH_DEF;
            fill = 0;
         end
      endcase
      o.position = POS_W'(p);
      o.entry_count = CNT_W'(fill);
      return o;
   endfunction

   function automatic void add_line(opcode_type op, int h, int k, bit typed = 1'b0,
         status_type st = STS_OK, int pos = 0, bit srt = 1'b0, int cnt = 0);
      script_line_type s;
      s.req.opcode = op;
      s.req.handle = HANDLE_W'(h);
      s.req.key = REQ_KEY_W'(k);
      s.typed = typed;
      s.want.status = st;
      s.want.position = POS_W'(pos);
      s.want.was_sorted = srt;
      s.want.entry_count = CNT_W'(cnt);
      plan.push_back(s);
   endfunction

   function automatic logic signed [REQ_KEY_W-1:0] draw_key();
      logic signed [REQ_KEY_W-1:0] k;
      case ($urandom_range(0, 9))
         0: k = 16'sh7fff;
         1: k = 16'sh8000;
         2, 3: k = REQ_KEY_W'($urandom_range(0, 15)) - 16'sd8;
         4, 5: begin
            if (fill != 0) k = slot_key[$urandom_range(0, fill - 1)];
            else k = REQ_KEY_W'($urandom());
         end
         default: k = REQ_KEY_W'($urandom());
      endcase
      return k;
   endfunction

   function automatic req_type draw_request();
      req_type     r;
      int unsigned w;
      int          tries;
      w = $urandom_range(0, 99);
      if (w < 28) r.opcode = OP_INSERT;
      else if (w < 33) r.opcode = OP_APPEND;
      else if (w < 50) r.opcode = OP_REMOVE;
      else if (w < 68) r.opcode = OP_MOVE;
      else if (w < 81) r.opcode = OP_LOWER;
      else if (w < 94) r.opcode = OP_UPPER;
      else if (w < 98) r.opcode = OP_SORT;
      else r.opcode = OP_CLEAR;
      r.handle = HANDLE_W'($urandom_range(0, 63));
      if ((r.opcode == OP_REMOVE || r.opcode == OP_MOVE) && fill != 0
            && $urandom_range(0, 4) != 0)
         r.handle = slot_owner[$urandom_range(0, fill - 1)];
      if ((r.opcode == OP_INSERT || r.opcode == OP_APPEND) && $urandom_range(0, 4) != 0) begin
         tries = 0;
         while (where_is[r.handle] < DEPTH_DEF && tries < 8) begin
            r.handle = HANDLE_W'($urandom_range(0, 63));
            tries++;
         end
      end
      r.key = draw_key();
      return r;
   endfunction

   task automatic issue(req_type r, bit typed, rsp_type given);
      rsp_type predicted;
      if (stall_odds != 0 && $urandom_range(0, 7) < stall_odds) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = table_apply(r);
      want_q.push_back(typed ? given : predicted);
   endtask

   always @(posedge clock) begin
      if (stall_left != 0) begin
         rsp_stall <= 1'b1;
         stall_left <= stall_left - 1;
      end else if (stall_odds != 0 && $urandom_range(0, 7) < stall_odds) begin
         rsp_stall <= 1'b1;
         stall_left <= $urandom_range(0, 9);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (want_q.size() == 0) begin
            $error("response with no request outstanding");
            fails++;
         end else begin
            want = want_q.pop_front();
            if (rsp_payload.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_payload.status);
               fails++;
            end
            if (rsp_payload.position !== want.position) begin
               $error("position: expected %0d, got %0d", want.position,
                  rsp_payload.position);
               fails++;
            end
            if (rsp_payload.was_sorted !== want.was_sorted) begin
               $error("was_sorted: expected %0d, got %0d", want.was_sorted,
                  rsp_payload.was_sorted);
               fails++;
            end
            if (rsp_payload.entry_count !== want.entry_count) begin
               $error("entry_count: expected %0d, got %0d", want.entry_count,
                  rsp_payload.entry_count);
               fails++;
            end
         end
      end
   end

   initial begin
      int unsigned order [64];
      int unsigned j;
      int unsigned t;
      req_type     r;
      foreach (where_is[i]) where_is[i] = DEPTH_DEF;
      fill = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      add_line(OP_LOWER, 0, 0, 1'b1, STS_OK, 0, 1'b0, 0);
      add_line(OP_UPPER, 63, -32768, 1'b1, STS_OK, 0, 1'b0, 0);
      add_line(OP_REMOVE, 5, 0, 1'b1, STS_ABSENT, 0, 1'b0, 0);
      add_line(OP_MOVE, 5, 100, 1'b1, STS_ABSENT, 0, 1'b0, 0);
      add_line(OP_SORT, 0, 0, 1'b1, STS_OK, 0, 1'b1, 0);
      add_line(OP_INSERT, 0, 0, 1'b1, STS_OK, 0, 1'b0, 1);
      add_line(OP_INSERT, 0, 5, 1'b1, STS_PRESENT, 0, 1'b0, 1);
      add_line(OP_MOVE, 0, 32767, 1'b1, STS_OK, 0, 1'b0, 1);
      add_line(OP_INSERT, 63, 32767);
      add_line(OP_INSERT, 1, -32768);
      add_line(OP_APPEND, 2, -100);
      add_line(OP_APPEND, 2, 7, 1'b1, STS_PRESENT, 0, 1'b0, 4);
      add_line(OP_LOWER, 0, 0);
      add_line(OP_UPPER, 0, 32767);
      add_line(OP_LOWER, 0, -32768);
      add_line(OP_SORT, 0, 0);
      add_line(OP_SORT, 0, 0, 1'b1, STS_OK, 0, 1'b1, 4);
      add_line(OP_MOVE, 1, 32767);
      add_line(OP_MOVE, 63, -32768);
      add_line(OP_INSERT, 42, 'h5555);
      add_line(OP_INSERT, 21, 'hAAAA);
      add_line(OP_REMOVE, 2, 0);
      add_line(OP_REMOVE, 2, 0, 1'b1, STS_ABSENT, 0, 1'b0, 5);
      add_line(OP_CLEAR, 0, 0, 1'b1, STS_OK, 0, 1'b0, 0);
      add_line(OP_LOWER, 0, 0, 1'b1, STS_OK, 0, 1'b0, 0);

      stall_odds = 2;
      foreach (plan[n]) issue(plan[n].req, plan[n].typed, plan[n].want);

      while (random_sent < RANDOM_ITEMS) begin
         stall_odds = (random_sent >= CALM_AFTER) ? 0 : $urandom_range(0, 3);
         if ($urandom_range(0, 5) == 0) begin
            // 64 handles fill 64 slots, so a full table always finds the handle present
            r = '0;
            r.opcode = OP_CLEAR;
            issue(r, 1'b0, '0);
            foreach (order[i]) order[i] = i;
            for (int unsigned i = 63; i > 0; i--) begin
               j = $urandom_range(0, i);
               t = order[i];
               order[i] = order[j];
               order[j] = t;
            end
            foreach (order[i]) begin
               r.opcode = ($urandom_range(0, 4) == 0) ? OP_APPEND : OP_INSERT;
               r.handle = HANDLE_W'(order[i]);
               r.key = draw_key();
               issue(r, 1'b0, '0);
            end
            random_sent += 65;
         end
         repeat ($urandom_range(20, 60)) begin
            issue(draw_request(), 1'b0, '0);
            random_sent++;
         end
      end
      stall_odds = 0;
      req_valid <= 1'b0;

      while (want_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fails == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end

endmodule
